### rtl/lmn_pkg.sv
`timescale 1ns / 1ps

package lmn_pkg;

   // Sizes of the node table and of the Lamport clock.
   localparam int MAX_NODES  = 16;
   localparam int NODE_BITS  = $clog2(MAX_NODES);
   localparam int COUNT_BITS = $clog2(MAX_NODES + 1);
   localparam int CLOCK_BITS = 32;

   // Configuration register indexes.
   localparam logic CSR_OWN_RANK   = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;

   // Reset value of the node count register.
   localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = COUNT_BITS'(2);

   typedef enum logic [1:0] {
      MODE_LOCAL   = 2'd0,
      MODE_REQUEST = 2'd1,
      MODE_ACK     = 2'd2,
      MODE_FREE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ENTRY_REQUEST = 2'd0,
      ENTRY_FREE    = 2'd1,
      ENTRY_ACK     = 2'd2
   } entry_state_type;

   typedef enum logic [1:0] {
      MSG_REQUEST = 2'd0,
      MSG_ACK     = 2'd1,
      MSG_FREE    = 2'd2
   } msg_kind_type;

   // Effective configuration after clamping.
   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [NODE_BITS-1:0]  rank;
   } cfg_type;

   // Table write request.
   typedef struct packed {
      logic                  en;
      logic [NODE_BITS-1:0]  addr;
      entry_state_type       state;
      logic [CLOCK_BITS-1:0] clock;
   } table_wr_type;

   // Table read request.
   typedef struct packed {
      logic                 en;
      logic [NODE_BITS-1:0] addr;
   } table_rd_type;

   // Table read data, valid in the cycle after the read request.
   typedef struct packed {
      entry_state_type       state;
      logic [CLOCK_BITS-1:0] clock;
   } table_data_type;

   // One outgoing message offered by the sequencer.
   typedef struct packed {
      logic                  valid;
      msg_kind_type          kind;
      logic [NODE_BITS-1:0]  dest;
      logic [CLOCK_BITS-1:0] clock;
      logic                  entered;
      logic                  last;
   } emit_type;

endpackage

### rtl/lmn_table.sv
`timescale 1ns / 1ps

module lmn_table
   import lmn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  table_wr_type   wr,
   input  table_rd_type   rd,
   output table_data_type rd_data
);

   logic [CLOCK_BITS+1:0] mem [MAX_NODES];
   logic [MAX_NODES-1:0]  valid_ff;
   logic [CLOCK_BITS+1:0] rd_word_ff;
   logic                  rd_valid_ff;

   // Storage array with a registered read port. Reads and writes of the same
   // entry are never issued in one cycle by the sequencer.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= {wr.state, wr.clock};
      end
      if (rd.en) begin
         rd_word_ff <= mem[rd.addr];
      end
   end

   // Valid bits: an entry never written reads as free with a zero clock.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            rd_valid_ff <= valid_ff[rd.addr];
         end
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_data.state = entry_state_type'(rd_word_ff[CLOCK_BITS+1:CLOCK_BITS]);
         rd_data.clock = rd_word_ff[CLOCK_BITS-1:0];
      end else begin
         rd_data.state = ENTRY_FREE;
         rd_data.clock = '0;
      end
   end

endmodule

### rtl/lmn_ctrl.sv
`timescale 1ns / 1ps

module lmn_ctrl
   import lmn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mode_type              req_mode,
   input  logic [NODE_BITS-1:0]  req_sender,
   input  logic [CLOCK_BITS-1:0] req_sender_clock,
   output table_wr_type          wr,
   output table_rd_type          rd,
   input  table_data_type        rd_data,
   output emit_type              emit,
   input  logic                  slot_free
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACK,
      S_ACK_RD,
      S_GRANT_RD,
      S_GRANT_MINE,
      S_SCAN,
      S_BCAST
   } state_type;

   state_type             state_ff, state_in;
   logic [CLOCK_BITS-1:0] lclock_ff, lclock_in;
   logic                  pending_ff, pending_in;
   logic [NODE_BITS-1:0]  ack_ff, ack_in;
   logic [NODE_BITS-1:0]  sender_ff, sender_in;
   logic [CLOCK_BITS-1:0] rclk_ff, rclk_in;
   logic [CLOCK_BITS-1:0] msg_clock_ff, msg_clock_in;
   msg_kind_type          msg_kind_ff, msg_kind_in;
   logic                  entered_ff, entered_in;
   logic [NODE_BITS-1:0]  bidx_ff, bidx_in;
   logic [CLOCK_BITS-1:0] mine_ff, mine_in;
   logic [COUNT_BITS-1:0] scan_ff, scan_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [NODE_BITS-1:0]  chk_idx_ff, chk_idx_in;

   logic [COUNT_BITS-1:0] last_idx;
   logic                  sender_ok;
   logic [CLOCK_BITS-1:0] merged;
   logic                  ack_full;
   logic [NODE_BITS-1:0]  ack_next;
   logic                  blocked;
   logic                  bcast_last;

   assign last_idx  = cfg.count - COUNT_BITS'(1);
   assign req_stall = (state_ff != S_IDLE);
   assign sender_ok = ({1'b0, req_sender} < cfg.count) && (req_sender != cfg.rank);
   assign merged    = ((lclock_ff > req_sender_clock) ? lclock_ff : req_sender_clock)
                      + CLOCK_BITS'(1);
   assign ack_full  = ({1'b0, ack_ff} == last_idx);
   assign ack_next  = ({1'b0, ack_ff} < last_idx) ? ack_ff + NODE_BITS'(1) : ack_ff;

   // An entry blocks the grant when it holds an earlier request by clock, then rank.
   assign blocked = chk_valid_ff && (chk_idx_ff != cfg.rank)
                    && (rd_data.state == ENTRY_REQUEST)
                    && ((rd_data.clock < mine_ff)
                        || ((rd_data.clock == mine_ff) && (chk_idx_ff < cfg.rank)));

   // The final message of a broadcast goes to the highest rank other than our own.
   assign bcast_last = ({1'b0, bidx_ff} == last_idx)
                       || (({1'b0, bidx_ff} == last_idx - COUNT_BITS'(1))
                           && ({1'b0, cfg.rank} == last_idx));

   // Sequencer: one request at a time through the table.
   always_comb begin
      state_in     = state_ff;
      lclock_in    = lclock_ff;
      pending_in   = pending_ff;
      ack_in       = ack_ff;
      sender_in    = sender_ff;
      rclk_in      = rclk_ff;
      msg_clock_in = msg_clock_ff;
      msg_kind_in  = msg_kind_ff;
      entered_in   = entered_ff;
      bidx_in      = bidx_ff;
      mine_in      = mine_ff;
      scan_in      = scan_ff;
      chk_valid_in = chk_valid_ff;
      chk_idx_in   = chk_idx_ff;

      wr.en    = 1'b0;
      wr.addr  = cfg.rank;
      wr.state = ENTRY_FREE;
      wr.clock = lclock_ff;
      rd.en    = 1'b0;
      rd.addr  = cfg.rank;

      emit.valid   = 1'b0;
      emit.kind    = msg_kind_ff;
      emit.dest    = bidx_ff;
      emit.clock   = msg_clock_ff;
      emit.entered = entered_ff;
      emit.last    = bcast_last;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sender_in = req_sender;
               rclk_in   = req_sender_clock;
               unique case (req_mode)
                  MODE_LOCAL: begin
                     if (!pending_ff) begin
                        msg_clock_in = lclock_ff;
                        lclock_in    = lclock_ff + CLOCK_BITS'(1);
                        pending_in   = 1'b1;
                        ack_in       = '0;
                        wr.en        = 1'b1;
                        wr.addr      = cfg.rank;
                        wr.state     = ENTRY_REQUEST;
                        wr.clock     = lclock_ff;
                        msg_kind_in  = MSG_REQUEST;
                        entered_in   = 1'b0;
                        bidx_in      = '0;
                        state_in     = S_BCAST;
                     end
                  end
                  MODE_REQUEST: begin
                     if (sender_ok) begin
                        wr.en        = 1'b1;
                        wr.addr      = req_sender;
                        wr.state     = ENTRY_REQUEST;
                        wr.clock     = req_sender_clock;
                        msg_clock_in = merged;
                        lclock_in    = merged + CLOCK_BITS'(1);
                        state_in     = S_ACK;
                     end
                  end
                  MODE_ACK: begin
                     if (sender_ok) begin
                        lclock_in = merged;
                        rd.en     = 1'b1;
                        rd.addr   = req_sender;
                        state_in  = S_ACK_RD;
                     end
                  end
                  MODE_FREE: begin
                     if (sender_ok) begin
                        lclock_in = merged;
                        wr.en     = 1'b1;
                        wr.addr   = req_sender;
                        wr.state  = ENTRY_FREE;
                        wr.clock  = req_sender_clock;
                        if (pending_ff && ack_full) begin
                           state_in = S_GRANT_RD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Single reply to a received request.
         S_ACK: begin
            emit.valid   = 1'b1;
            emit.kind    = MSG_ACK;
            emit.dest    = sender_ff;
            emit.entered = 1'b0;
            emit.last    = 1'b1;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end

         // The sender's entry is back: record the ACK unless it holds a request.
         S_ACK_RD: begin
            if (rd_data.state != ENTRY_REQUEST) begin
               wr.en    = 1'b1;
               wr.addr  = sender_ff;
               wr.state = ENTRY_ACK;
               wr.clock = rclk_ff;
            end
            state_in = S_IDLE;
            if (pending_ff) begin
               ack_in = ack_next;
               if ({1'b0, ack_next} == last_idx) begin
                  state_in = S_GRANT_RD;
               end
            end
         end

         S_GRANT_RD: begin
            rd.en    = 1'b1;
            rd.addr  = cfg.rank;
            state_in = S_GRANT_MINE;
         end

         S_GRANT_MINE: begin
            mine_in      = rd_data.clock;
            scan_in      = '0;
            chk_valid_in = 1'b0;
            state_in     = S_SCAN;
         end

         // Read one entry a cycle and check it in the following cycle.
         S_SCAN: begin
            if (blocked) begin
               chk_valid_in = 1'b0;
               state_in     = S_IDLE;
            end else if (scan_ff < cfg.count) begin
               rd.en        = 1'b1;
               rd.addr      = scan_ff[NODE_BITS-1:0];
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_ff[NODE_BITS-1:0];
               scan_in      = scan_ff + COUNT_BITS'(1);
            end else if (chk_valid_ff) begin
               chk_valid_in = 1'b0;
            end else begin
               msg_clock_in = lclock_ff;
               lclock_in    = lclock_ff + CLOCK_BITS'(1);
               pending_in   = 1'b0;
               ack_in       = '0;
               wr.en        = 1'b1;
               wr.addr      = cfg.rank;
               wr.state     = ENTRY_FREE;
               wr.clock     = lclock_ff;
               msg_kind_in  = MSG_FREE;
               entered_in   = 1'b1;
               bidx_in      = '0;
               state_in     = S_BCAST;
            end
         end

         // One message per free output slot, our own rank skipped.
         S_BCAST: begin
            if (bidx_ff == cfg.rank) begin
               bidx_in = bidx_ff + NODE_BITS'(1);
            end else begin
               emit.valid = 1'b1;
               if (slot_free) begin
                  bidx_in = bidx_ff + NODE_BITS'(1);
                  if (bcast_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lclock_ff    <= '0;
         pending_ff   <= 1'b0;
         ack_ff       <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lclock_ff    <= lclock_in;
         pending_ff   <= pending_in;
         ack_ff       <= ack_in;
         chk_valid_ff <= chk_valid_in;
      end
      sender_ff    <= sender_in;
      rclk_ff      <= rclk_in;
      msg_clock_ff <= msg_clock_in;
      msg_kind_ff  <= msg_kind_in;
      entered_ff   <= entered_in;
      bidx_ff      <= bidx_in;
      mine_ff      <= mine_in;
      scan_ff      <= scan_in;
      chk_idx_ff   <= chk_idx_in;
   end

endmodule

### rtl/lamport_mutex_node_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    mode, sender, sender_clock
// rsp_      out        rsp_valid/stall    message_kind, destination, message_clock,
//                                         entered_section, last
// csr_      in         csr_write          csr_index, csr_data
//
// One request at a time. A received REQUEST writes its entry and then sends the ACK; a
// FREE writes its entry and, with every ACK in, starts a grant check; an ACK reads the
// entry first. A grant check reads each table entry in turn through the single read port
// of the table memory, and a broadcast waits whenever rsp_stall holds the output.
// Reset clears the clock, the pending flag, the ACK count and the valid bits of the
// table at once; no clearing pass is needed. req_stall is high while a request is in
// work; the output register lets the next request in while the final message waits.

module lamport_mutex_node_core
   import lmn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [NODE_BITS-1:0]  req_sender,
   input  logic [CLOCK_BITS-1:0] req_sender_clock,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_message_kind,
   output logic [NODE_BITS-1:0]  rsp_destination,
   output logic [CLOCK_BITS-1:0] rsp_message_clock,
   output logic                  rsp_entered_section,
   output logic                  rsp_last,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [COUNT_BITS-1:0] csr_data
);

   logic [NODE_BITS-1:0]  own_rank_ff;
   logic [COUNT_BITS-1:0] node_count_ff;
   cfg_type               cfg;
   table_wr_type          wr;
   table_rd_type          rd;
   table_data_type        rd_data;
   emit_type              emit;
   logic                  slot_free;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_kind_ff;
   logic [NODE_BITS-1:0]  rsp_dest_ff;
   logic [CLOCK_BITS-1:0] rsp_clock_ff;
   logic                  rsp_entered_ff;
   logic                  rsp_last_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_rank_ff   <= '0;
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OWN_RANK:   own_rank_ff   <= csr_data[NODE_BITS-1:0];
            CSR_NODE_COUNT: node_count_ff <= csr_data[COUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the node count and fold an out-of-range rank onto the highest one.
   always_comb begin
      if (node_count_ff < COUNT_BITS'(2)) begin
         cfg.count = COUNT_BITS'(2);
      end else if (node_count_ff > COUNT_BITS'(MAX_NODES)) begin
         cfg.count = COUNT_BITS'(MAX_NODES);
      end else begin
         cfg.count = node_count_ff;
      end
      if ({1'b0, own_rank_ff} < cfg.count) begin
         cfg.rank = own_rank_ff;
      end else begin
         cfg.rank = NODE_BITS'(cfg.count - COUNT_BITS'(1));
      end
   end

   lmn_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   lmn_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (mode_type'(req_mode)),
      .req_sender       (req_sender),
      .req_sender_clock (req_sender_clock),
      .wr               (wr),
      .rd               (rd),
      .rd_data          (rd_data),
      .emit             (emit),
      .slot_free        (slot_free)
   );

   // Output register between the sequencer and the result channel.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= emit.valid;
      end
      if (slot_free && emit.valid) begin
         rsp_kind_ff    <= emit.kind;
         rsp_dest_ff    <= emit.dest;
         rsp_clock_ff   <= emit.clock;
         rsp_entered_ff <= emit.entered;
         rsp_last_ff    <= emit.last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_message_kind    = rsp_kind_ff;
   assign rsp_destination     = rsp_dest_ff;
   assign rsp_message_clock   = rsp_clock_ff;
   assign rsp_entered_section = rsp_entered_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

### tb/tb_lamport_mutex_node_core.sv
`timescale 1ns / 1ps

module tb_lamport_mutex_node_core;
   import lmn_pkg::*;

   // One outgoing message as seen on the result channel.
   typedef struct packed {
      msg_kind_type kind;
      logic [3:0]   dest;
      logic [31:0]  stamp;
      logic         entered;
      logic         is_last;
   } message_t;

   // Lamport node predictor with its queue of messages still due from the block.
   class node_scoreboard;
      logic [3:0]      own_rank;
      logic [4:0]      node_count;
      logic [31:0]     lamport_clock;
      logic            request_pending;
      int unsigned     ack_count;
      entry_state_type entry_state [MAX_NODES];
      logic [31:0]     entry_stamp [MAX_NODES];
      message_t        due_messages [$];
      message_t        burst [$];
      int unsigned     errors;

      function new();
         own_rank = 4'd0;
         node_count = 5'd2;
         lamport_clock = 32'd0;
         request_pending = 1'b0;
         ack_count = 0;
         errors = 0;
         for (int i = 0; i < MAX_NODES; i++) begin
            entry_state[i] = ENTRY_FREE;
            entry_stamp[i] = 32'd0;
         end
      endfunction

      // Node count clamped to between two and the size of the table.
      function int unsigned count_used();
         int unsigned n;
         n = 32'(node_count);
         if (n < 2) n = 2;
         if (n > MAX_NODES) n = MAX_NODES;
         return n;
      endfunction

      // A rank beyond the node count falls back to the highest rank.
      function int unsigned rank_used();
         int unsigned n;
         n = count_used();
         return (32'(own_rank) < n) ? 32'(own_rank) : n - 1;
      endfunction

      function void set_register(logic index, logic [4:0] value);
         if (index == CSR_OWN_RANK) begin
            own_rank = value[3:0];
         end else begin
            node_count = value;
         end
      endfunction

      function void add_message(msg_kind_type kind, int unsigned dest, logic entered);
         message_t m;
         m.kind = kind;
         m.dest = 4'(dest);
         m.stamp = lamport_clock;
         m.entered = entered;
         m.is_last = 1'b0;
         burst.push_back(m);
      endfunction

      function void broadcast(msg_kind_type kind, logic entered);
         int unsigned n, me;
         n = count_used();
         me = rank_used();
         for (int unsigned i = 0; i < n; i++) begin
            if (i != me) add_message(kind, i, entered);
         end
      endfunction

      // Enter once every ACK is in and no earlier REQUEST is held, then release.
      function void try_enter();
         int unsigned n, me;
         logic [31:0] mine;
         n = count_used();
         me = rank_used();
         mine = entry_stamp[me];
         if (!request_pending || ack_count != n - 1) return;
         for (int unsigned i = 0; i < n; i++) begin
            if (i == me || entry_state[i] != ENTRY_REQUEST) continue;
            if (entry_stamp[i] < mine || (entry_stamp[i] == mine && i < me)) return;
         end
         broadcast(MSG_FREE, 1'b1);
         request_pending = 1'b0;
         ack_count = 0;
         entry_state[me] = ENTRY_FREE;
         entry_stamp[me] = lamport_clock;
         lamport_clock = lamport_clock + 32'd1;
      endfunction

      // Notes an accepted request; returns 1 unless the block ignores it.
      function bit take_request(mode_type mode, logic [3:0] sender, logic [31:0] stamp);
         int unsigned n, me;
         message_t m;
         n = count_used();
         me = rank_used();
         burst.delete();
         if (mode == MODE_LOCAL) begin
            if (request_pending) return 1'b0;
            broadcast(MSG_REQUEST, 1'b0);
            request_pending = 1'b1;
            ack_count = 0;
            entry_state[me] = ENTRY_REQUEST;
            entry_stamp[me] = lamport_clock;
            lamport_clock = lamport_clock + 32'd1;
         end else begin
            if (32'(sender) >= n || 32'(sender) == me) return 1'b0;
            lamport_clock = ((lamport_clock > stamp) ? lamport_clock : stamp) + 32'd1;
            case (mode)
               MODE_REQUEST: begin
                  entry_state[sender] = ENTRY_REQUEST;
                  entry_stamp[sender] = stamp;
                  add_message(MSG_ACK, 32'(sender), 1'b0);
                  lamport_clock = lamport_clock + 32'd1;
               end
               MODE_ACK: begin
                  if (entry_state[sender] != ENTRY_REQUEST) begin
                     entry_state[sender] = ENTRY_ACK;
                     entry_stamp[sender] = stamp;
                  end
                  if (request_pending) begin
                     if (ack_count < n - 1) ack_count++;
                     try_enter();
                  end
               end
               default: begin
                  entry_state[sender] = ENTRY_FREE;
                  entry_stamp[sender] = stamp;
                  try_enter();
               end
            endcase
         end
         // The final message of the burst carries the last flag.
         if (burst.size() > 0) begin
            m = burst[burst.size() - 1];
            m.is_last = 1'b1;
            burst[burst.size() - 1] = m;
         end
         foreach (burst[i]) due_messages.push_back(burst[i]);
         return 1'b1;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_message(message_t got);
         message_t want;
         if (due_messages.size() == 0) begin
            $error("message with no expectation: kind %0d, destination %0d, clock %0d",
                   got.kind, got.dest, got.stamp);
            errors++;
            return;
         end
         want = due_messages.pop_front();
         compare_field("message_kind", 32'(want.kind), 32'(got.kind));
         compare_field("destination", 32'(want.dest), 32'(got.dest));
         compare_field("message_clock", want.stamp, got.stamp);
         compare_field("entered_section", 32'(want.entered), 32'(got.entered));
         compare_field("last", 32'(want.is_last), 32'(got.is_last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = 2'd0;
   logic [3:0]  req_sender = 4'd0;
   logic [31:0] req_sender_clock = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_message_kind;
   logic [3:0]  rsp_destination;
   logic [31:0] rsp_message_clock;
   logic        rsp_entered_section;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [4:0]  csr_data = 5'd0;

   node_scoreboard sb = new();
   bit             calm = 1'b0;
   int unsigned    handled_items = 0;

   lamport_mutex_node_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_sender          (req_sender),
      .req_sender_clock    (req_sender_clock),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_message_kind    (rsp_message_kind),
      .rsp_destination     (rsp_destination),
      .rsp_message_clock   (rsp_message_clock),
      .rsp_entered_section (rsp_entered_section),
      .rsp_last            (rsp_last),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random, except during the calm phase.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 35);
   end

   // Every accepted message is checked against the oldest one due.
   always @(posedge clock) begin : watch_messages
      message_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = msg_kind_type'(rsp_message_kind);
         got.dest = rsp_destination;
         got.stamp = rsp_message_clock;
         got.entered = rsp_entered_section;
         got.is_last = rsp_last;
         sb.check_message(got);
      end
   end

   // Offers one request, at times after a random gap, and waits until it is taken.
   task automatic send_request(mode_type mode, logic [3:0] sender, logic [31:0] stamp);
      int gap;
      if (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         gap = $urandom_range(4, 1);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sender <= sender;
      req_sender_clock <= stamp;
      do @(posedge clock); while (req_stall);
      if (sb.take_request(mode, sender, stamp)) handled_items++;
   endtask

   // Stops offering and waits for every due message plus the grant-check time.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.due_messages.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic configure(logic [3:0] rank, logic [4:0] count);
      drain();
      csr_write <= 1'b1;
      csr_index <= CSR_OWN_RANK;
      csr_data <= {1'b0, rank};
      @(posedge clock);
      sb.set_register(CSR_OWN_RANK, {1'b0, rank});
      csr_index <= CSR_NODE_COUNT;
      csr_data <= count;
      @(posedge clock);
      sb.set_register(CSR_NODE_COUNT, count);
      csr_write <= 1'b0;
   endtask

   // Sender clocks around our own request clock, so that ties and near misses occur.
   function automatic logic [31:0] near_stamp(logic [31:0] own);
      case ($urandom_range(3))
         0: return own - 32'd1;
         1: return own;
         2: return own + 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // One mutual exclusion round: local request, rival requests, ACKs, then FREEs.
   task automatic play_round();
      int unsigned n, me, j, tmp;
      logic [31:0] own;
      int unsigned others [$];
      bit asked [MAX_NODES];
      n = sb.count_used();
      me = sb.rank_used();
      foreach (asked[i]) asked[i] = 1'b0;
      send_request(MODE_LOCAL, 4'($urandom_range(15)), $urandom);
      own = sb.entry_stamp[me];
      // Fewer than two rival requests per round on average, whatever the node count.
      for (int unsigned i = 0; i < n; i++) begin
         if (i == me) continue;
         others.push_back(i);
         if ($urandom_range(n - 1) < 2) begin
            send_request(MODE_REQUEST, 4'(i), near_stamp(own));
            asked[i] = 1'b1;
         end
      end
      // ACKs arrive in random order, with some noise, repeats and abandoned rounds.
      for (int i = others.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = others[i];
         others[i] = others[j];
         others[j] = tmp;
      end
      foreach (others[i]) begin
         if ($urandom_range(99) < 8)
            send_request(mode_type'($urandom_range(3)), 4'($urandom_range(15)), $urandom);
         send_request(MODE_ACK, 4'(others[i]), near_stamp(own));
         if ($urandom_range(99) < 10)
            send_request(MODE_ACK, 4'(others[i]), $urandom);
         if ($urandom_range(99) < 4) break;
      end
      foreach (others[i]) begin
         if (asked[others[i]]) send_request(MODE_FREE, 4'(others[i]), $urandom);
      end
   endtask

   typedef struct {
      logic [3:0] rank;
      logic [4:0] count;
   } setting_t;

   initial begin : stimulus
      logic [31:0] own;
      int unsigned start;
      setting_t settings [7];
      settings = '{'{4'd15, 5'd16}, '{4'd0, 5'd31}, '{4'd7, 5'd1}, '{4'd2, 5'd3},
                   '{4'd9, 5'd17}, '{4'd4, 5'd5}, '{4'd1, 5'd4}};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: rank 0 of two nodes.
      send_request(MODE_ACK, 4'd1, 32'd5);             // ACK with nothing pending
      send_request(MODE_REQUEST, 4'd1, 32'hFFFF_FFFF); // clock wraps
      send_request(MODE_FREE, 4'd1, 32'd3);            // FREE with nothing pending
      send_request(MODE_LOCAL, 4'd0, 32'd0);
      send_request(MODE_LOCAL, 4'd15, 32'hFFFF_FFFF); // already pending
      send_request(MODE_ACK, 4'd0, 32'd7);             // from ourselves
      send_request(MODE_ACK, 4'd9, 32'd7);             // rank beyond the node count
      send_request(MODE_ACK, 4'd1, 32'd8);             // grants and releases
      send_request(MODE_ACK, 4'd1, 32'd9);

      // Count below range and rank beyond it: two nodes, we are rank 1.
      configure(4'd3, 5'd0);
      send_request(MODE_LOCAL, 4'd0, 32'd0);
      own = sb.entry_stamp[sb.rank_used()];
      send_request(MODE_REQUEST, 4'd0, own);           // tie, lower rank wins
      send_request(MODE_ACK, 4'd0, 32'd1);             // counted but blocked
      send_request(MODE_ACK, 4'd0, 32'd2);             // surplus ACK saturates
      send_request(MODE_FREE, 4'd0, 32'd0);            // unblocks the grant
      send_request(MODE_REQUEST, 4'd0, 32'd0);
      send_request(MODE_LOCAL, 4'd0, 32'd0);           // earlier rival blocks us
      send_request(MODE_ACK, 4'd0, 32'hFFFF_FFF0);
      send_request(MODE_FREE, 4'd0, 32'd0);

      // Random rounds under several settings; one phase runs with no idling at all.
      foreach (settings[p]) begin
         configure(settings[p].rank, settings[p].count);
         calm = (p == 3);
         start = handled_items;
         while (handled_items - start < 6) play_round();
      end

      drain();
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Guard against a block that stops answering.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
